FILE: rtl/perlin_noise_3d_eval_unit_assert.svh
// Assertion macros for the 3D gradient noise unit.
`ifndef PERLIN_NOISE_3D_EVAL_UNIT_ASSERT_SVH
`define PERLIN_NOISE_3D_EVAL_UNIT_ASSERT_SVH
// Implication checked every cycle outside reset.
`define PN_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PN_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: rtl/pn3d_pkg.sv
// Package with shared constants, tables and helpers of the noise unit.
`timescale 1ns / 1ps
package pn3d_pkg;
   localparam int TableEntriesDefault = 256;
   localparam int FracBitsDefault     = 16;
   localparam int OutWidth            = 18;
   localparam int CfgIdxWidth         = 2;
   localparam logic [CfgIdxWidth-1:0] CFG_WRAP_X = 2'd0;
   localparam logic [CfgIdxWidth-1:0] CFG_WRAP_Y = 2'd1;
   localparam logic [CfgIdxWidth-1:0] CFG_WRAP_Z = 2'd2;

   // Gradient for a hash: 2 bits per axis, {nonzero, negative}.
   function automatic logic [5:0] grad_code(input logic [5:0] h);
      logic [3:0] g;
      logic [5:0] t;
      logic [5:0] r;
      t = h - 6'd16;
      if (h < 6'd12) begin
         g = h[3:0];
      end else if (h inside {[6'd12:6'd15]}) begin
         case (h[1:0])
            2'd0: g = 4'd0;
            2'd1: g = 4'd9;
            2'd2: g = 4'd1;
            default: g = 4'd11;
         endcase
      end else begin
         // fold hashes from 16 to 63 back onto the edge gradient codes 0 to 11
         if (t >= 6'd36)      g = 4'(t - 6'd36);
         else if (t >= 6'd24) g = 4'(t - 6'd24);
         else if (t >= 6'd12) g = 4'(t - 6'd12);
         else                 g = t[3:0];
      end
      case (g)
         4'd0:  r = 6'b10_10_00;
         4'd1:  r = 6'b11_10_00;
         4'd2:  r = 6'b10_11_00;
         4'd3:  r = 6'b11_11_00;
         4'd4:  r = 6'b10_00_10;
         4'd5:  r = 6'b11_00_10;
         4'd6:  r = 6'b10_00_11;
         4'd7:  r = 6'b11_00_11;
         4'd8:  r = 6'b00_10_10;
         4'd9:  r = 6'b00_11_10;
         4'd10: r = 6'b00_10_11;
         default: r = 6'b00_11_11;
      endcase
      return r;
   endfunction
endpackage

FILE: rtl/perlin_noise_3d_eval_unit.sv
// Top level of the 3D gradient noise evaluation unit.
`timescale 1ns / 1ps
// 3D improved gradient noise, one point per cycle while rsp_* is not stalled.
// Channels: req_* carries an item (mode, pos_x/y/z, entry_index, entry_value);
//   mode 0 evaluates noise at a signed fixed point position, mode 1 writes
//   one byte of the permutation table and gives no result.
// rsp_* returns noise_value, 18-bit signed with 16 fraction bits.
// csr_* writes wrap_x/y/z (index 0..2); write only while idle.
// Throughput: one item per cycle; the pipeline advances as one unit whenever
//   its last stage is empty or being taken.
// rsp_valid rises when the item reaches the last pipeline stage. The three
//   dependent table lookups (corner x, then y, then z) each use their own RAM
//   copies with registered read, and the fade polynomial needs four multiplies.
// Each mode 1 item writes all 14 table copies, one lookup level per advance,
//   so every evaluation sees exactly the writes accepted before it.
// Reset clears all valid bits and wrap registers; the table stays undefined
//   until written.
// A stalled receiver holds rsp_*; the whole pipeline holds with it.
module perlin_noise_3d_eval_unit
   import pn3d_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault,
   parameter int FRAC_BITS     = FracBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic signed [31:0]     req_pos_x,
   input  logic signed [31:0]     req_pos_y,
   input  logic signed [31:0]     req_pos_z,
   input  logic [7:0]             req_entry_index,
   input  logic [7:0]             req_entry_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [OutWidth-1:0] rsp_noise_value,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CfgIdxWidth-1:0] csr_index,
   input  logic [8:0]             csr_data
);
`include "perlin_noise_3d_eval_unit_assert.svh"
   localparam int F  = FRAC_BITS;
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int NS = 14;          // pipeline stages
   // working width for fixed point values: |v| < 16*2^F (fade starts near -15)
   localparam int VW = F + 5;
   localparam logic signed [VW-1:0] ONE = VW'(1) <<< F;

   typedef logic signed [VW-1:0] val_type;

   logic [8:0] wrap_ff [3];
   logic [NS-1:0] vld_ff;
   logic adv;
   assign adv = !vld_ff[NS-1] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   logic acc, wr;
   assign acc = req_valid && req_ready && !req_mode;
   assign wr  = req_valid && req_ready && req_mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         wrap_ff[0] <= '0;
         wrap_ff[1] <= '0;
         wrap_ff[2] <= '0;
      end else begin
         if (adv) vld_ff <= {vld_ff[NS-2:0], acc};
         if (csr_valid) begin
            case (csr_index)
               CFG_WRAP_X: wrap_ff[0] <= csr_data;
               CFG_WRAP_Y: wrap_ff[1] <= csr_data;
               CFG_WRAP_Z: wrap_ff[2] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Stage 0: split into cell and fraction, wrap the cells.
   logic [AW-1:0] lo_ff [3], hi_ff [3];
   val_type fr_ff [5][3];
   logic signed [31:0] pos [3];
   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            logic [AW-1:0] m, c;
            m = AW'(wrap_ff[i] - 9'd1);
            c = AW'(pos[i] >>> F);
            lo_ff[i] <= c & m;
            hi_ff[i] <= (c + AW'(1)) & m;
            fr_ff[0][i] <= val_type'({1'b0, pos[i][F-1:0]});
         end
         for (int s = 1; s < 5; s++) fr_ff[s] <= fr_ff[s-1];
      end
   end

   // Fade: stages 1..5 per axis.
   val_type fa_ff [5][3];
   function automatic val_type fm(input val_type a, input val_type b);
      logic signed [2*VW-1:0] p;
      p = a * b;
      return VW'(p >>> F);
   endfunction
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            fa_ff[0][i] <= VW'(6) * fr_ff[0][i] - VW'(15) * ONE;
            fa_ff[1][i] <= fm(fa_ff[0][i], fr_ff[1][i]) + VW'(10) * ONE;
            fa_ff[2][i] <= fm(fa_ff[1][i], fr_ff[2][i]);
            fa_ff[3][i] <= fm(fa_ff[2][i], fr_ff[3][i]);
            fa_ff[4][i] <= fm(fa_ff[3][i], fr_ff[4][i]);
         end
      end
   end
   // fade result fa_ff[4] valid at stage 5; delay to its blend stage.
   val_type w_ff [4], v_ff [5], u_ff [6];
   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff[0] <= fa_ff[4][2];
         v_ff[0] <= fa_ff[4][1];
         u_ff[0] <= fa_ff[4][0];
         for (int k = 1; k < 4; k++) w_ff[k] <= w_ff[k-1];
         for (int k = 1; k < 5; k++) v_ff[k] <= v_ff[k-1];
         for (int k = 1; k < 6; k++) u_ff[k] <= u_ff[k-1];
      end
   end

   // Hash lookups: 2 x-reads, 4 y-reads, 8 z-reads, in 3 RAM levels.
   // Level 1 reads at stage 0 (data at stage 1), level 2 at 1, level 3 at 2.
   logic [AW-1:0] ra [14];
   logic [7:0]    rd [14];
   logic [AW-1:0] lo1_ff [2][3], hi1_ff [2][3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            lo1_ff[0][i] <= lo_ff[i];  hi1_ff[0][i] <= hi_ff[i];
            lo1_ff[1][i] <= lo1_ff[0][i]; hi1_ff[1][i] <= hi1_ff[0][i];
         end
      end
   end
   assign ra[0] = lo_ff[0];
   assign ra[1] = hi_ff[0];
   assign ra[2] = AW'(rd[0] + 8'(lo1_ff[0][1]));
   assign ra[3] = AW'(rd[0] + 8'(hi1_ff[0][1]));
   assign ra[4] = AW'(rd[1] + 8'(lo1_ff[0][1]));
   assign ra[5] = AW'(rd[1] + 8'(hi1_ff[0][1]));
   for (genvar k = 0; k < 4; k++) begin : g_zaddr
      assign ra[6+2*k] = AW'(rd[2+k] + 8'(lo1_ff[1][2]));
      assign ra[7+2*k] = AW'(rd[2+k] + 8'(hi1_ff[1][2]));
   end

   // Table writes: level 1 copies take the write at acceptance, levels 2 and
   // 3 one and two advances later, after the last read of any older item.
   logic          wdl_ff [2];
   logic [AW-1:0] wda_ff [2];
   logic [7:0]    wdd_ff [2];
   always_ff @(posedge clock) begin
      if (reset) begin
         wdl_ff[0] <= 1'b0;
         wdl_ff[1] <= 1'b0;
      end else if (adv) begin
         wdl_ff[0] <= wr;
         wdl_ff[1] <= wdl_ff[0];
         wda_ff[0] <= req_entry_index[AW-1:0];
         wda_ff[1] <= wda_ff[0];
         wdd_ff[0] <= req_entry_value;
         wdd_ff[1] <= wdd_ff[0];
      end
   end
   logic          lvl_wr [3];
   logic [AW-1:0] lvl_wa [3];
   logic [7:0]    lvl_wd [3];
   assign lvl_wr[0] = wr;
   assign lvl_wa[0] = req_entry_index[AW-1:0];
   assign lvl_wd[0] = req_entry_value;
   assign lvl_wr[1] = wdl_ff[0] && adv;
   assign lvl_wa[1] = wda_ff[0];
   assign lvl_wd[1] = wdd_ff[0];
   assign lvl_wr[2] = wdl_ff[1] && adv;
   assign lvl_wa[2] = wda_ff[1];
   assign lvl_wd[2] = wdd_ff[1];

   for (genvar k = 0; k < 14; k++) begin : g_tab
      localparam int Lvl = (k < 2) ? 0 : ((k < 6) ? 1 : 2);
      pn3d_ram #(.Width(8), .Depth(TABLE_ENTRIES)) u_ram (
         .clock   (clock),
         .wr_en   (lvl_wr[Lvl]),
         .wr_addr (lvl_wa[Lvl]),
         .wr_data (lvl_wd[Lvl]),
         .rd_en   (adv),
         .rd_addr (ra[k]),
         .rd_data (rd[k])
      );
   end

   // Stage 4: gradient dots for the eight corners (z hashes valid now).
   val_type dot_ff [8];
   function automatic val_type gterm(input logic [1:0] g, input val_type d);
      return g[1] ? (g[0] ? -d : d) : '0;
   endfunction
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 8; c++) begin
            logic [5:0] g;
            val_type dx, dy, dz;
            g  = grad_code(rd[6+c][5:0]);
            dx = c[2] ? fr_ff[3][0] - ONE : fr_ff[3][0];
            dy = c[1] ? fr_ff[3][1] - ONE : fr_ff[3][1];
            dz = c[0] ? fr_ff[3][2] - ONE : fr_ff[3][2];
            dot_ff[c] <= gterm(g[5:4], dx) + gterm(g[3:2], dy) + gterm(g[1:0], dz);
         end
      end
   end
   // Delay dots from stage 5 to stage 9 where w is ready.
   val_type dd_ff [5][8];
   always_ff @(posedge clock) begin
      if (adv) begin
         dd_ff[0] <= dot_ff;
         for (int k = 1; k < 5; k++) dd_ff[k] <= dd_ff[k-1];
      end
   end
   // w valid at stage 9 = w_ff[3]; dd_ff[4] at stage 9.
   val_type nz_ff [4], ny_ff [2], nx_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++)
            nz_ff[k] <= dd_ff[4][2*k] + fm(dd_ff[4][2*k+1] - dd_ff[4][2*k], w_ff[3]);
         for (int k = 0; k < 2; k++)
            ny_ff[k] <= nz_ff[2*k] + fm(nz_ff[2*k+1] - nz_ff[2*k], v_ff[4]);
         nx_ff <= ny_ff[0] + fm(ny_ff[1] - ny_ff[0], u_ff[5]);
      end
   end
   // nx_ff at stage 12: rescale and saturate into output stage.
   logic signed [OutWidth-1:0] out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [VW+16:0] r;
         if (F >= 16) r = (VW+17)'(nx_ff >>> (F - 16));
         else         r = (VW+17)'(nx_ff) <<< (16 - F);
         if (r > 131071)       out_ff <= 18'sd131071;
         else if (r < -131072) out_ff <= -18'sd131072;
         else                  out_ff <= OutWidth'(r);
      end
   end
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_noise_value = out_ff;

   `PN_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_noise_value))
   `PN_ASSERT_IMPL(a_ready, clock, reset, !rsp_valid, req_ready)
   `PN_ASSERT_NEXT(a_flow, clock, reset, acc, vld_ff[0])
endmodule

FILE: rtl/pn3d_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pn3d_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: sim/tb_perlin_noise_3d_eval_unit.sv
// Self-checking testbench for the 3D gradient noise evaluation unit.
`timescale 1ns / 1ps
module tb_perlin_noise_3d_eval_unit;
   import pn3d_pkg::*;

   localparam int FRAC      = 16;
   localparam int LATENCY   = 14;
   localparam int WDOG_MAX  = 20000;
   localparam logic MODE_EVAL  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_mode = MODE_EVAL;
   logic signed [31:0]         req_pos_x = '0;
   logic signed [31:0]         req_pos_y = '0;
   logic signed [31:0]         req_pos_z = '0;
   logic [7:0]                 req_entry_index = '0;
   logic [7:0]                 req_entry_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [OutWidth-1:0] rsp_noise_value;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CfgIdxWidth-1:0]     csr_index = '0;
   logic [8:0]                 csr_data = '0;

   perlin_noise_3d_eval_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow state of the block: permutation bytes and wrap periods.
   logic [7:0]  perm_shadow [256];
   logic [8:0]  wrap_shadow [3];
   logic [17:0] noise_expected [$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          rsp_hold = 0;
   bit          rsp_stall_on = 1'b1;

   // Signed floor shift by the fraction width; >>> on longint floors.
   function automatic longint fx_mul(longint a, longint b);
      return (a * b) >>> FRAC;
   endfunction

   function automatic longint fade_curve(longint t);
      longint p;
      p = fx_mul(6 * t - 15 * (64'sd1 <<< FRAC), t) + 10 * (64'sd1 <<< FRAC);
      p = fx_mul(p, t);
      p = fx_mul(p, t);
      return fx_mul(p, t);
   endfunction

   function automatic longint mix(longint a, longint b, longint t);
      return a + fx_mul(b - a, t);
   endfunction

   // Dot product of the picked edge gradient with the corner offset.
   function automatic longint grad_dot(logic [7:0] h, longint dx, longint dy,
                                       longint dz);
      int g;
      int gx, gy, gz;
      g = h[5:0];
      if (g >= 12 && g < 16) begin
         case (g - 12)
            0: g = 0;
            1: g = 9;
            2: g = 1;
            default: g = 11;
         endcase
      end else if (g >= 16) begin
         g = (g - 16) % 12;
      end
      gx = (g < 8) ? ((g % 2) ? -1 : 1) : 0;
      gy = (g < 4) ? ((g < 2) ? 1 : -1) : (g >= 8) ? ((g % 2) ? -1 : 1) : 0;
      gz = (g < 4) ? 0 : (g < 8) ? ((g < 6) ? 1 : -1) : ((g < 10) ? 1 : -1);
      return gx * dx + gy * dy + gz * dz;
   endfunction

   function automatic logic [17:0] noise_at(logic [31:0] px, logic [31:0] py,
                                            logic [31:0] pz);
      longint fr [3];
      logic [7:0] lo [3], hi [3], msk [3];
      logic [31:0] p [3];
      longint one, u, v, w, n00, n01, n10, n11, n0, n1, r;
      logic [7:0] a0, a1, b00, b01, b10, b11;
      one = 64'sd1 <<< FRAC;
      p[0] = px; p[1] = py; p[2] = pz;
      for (int i = 0; i < 3; i++) begin
         msk[i] = 8'(wrap_shadow[i] - 9'd1);
         fr[i] = longint'(p[i][FRAC-1:0]);
         lo[i] = p[i][FRAC+7:FRAC] & msk[i];
         hi[i] = 8'(p[i][FRAC+7:FRAC] + 8'd1) & msk[i];
      end
      u = fade_curve(fr[0]);
      v = fade_curve(fr[1]);
      w = fade_curve(fr[2]);
      a0  = perm_shadow[lo[0]];
      a1  = perm_shadow[hi[0]];
      b00 = perm_shadow[8'(a0 + lo[1])];
      b01 = perm_shadow[8'(a0 + hi[1])];
      b10 = perm_shadow[8'(a1 + lo[1])];
      b11 = perm_shadow[8'(a1 + hi[1])];
      n00 = mix(grad_dot(perm_shadow[8'(b00 + lo[2])], fr[0], fr[1], fr[2]),
                grad_dot(perm_shadow[8'(b00 + hi[2])], fr[0], fr[1], fr[2] - one), w);
      n01 = mix(grad_dot(perm_shadow[8'(b01 + lo[2])], fr[0], fr[1] - one, fr[2]),
                grad_dot(perm_shadow[8'(b01 + hi[2])], fr[0], fr[1] - one,
                         fr[2] - one), w);
      n10 = mix(grad_dot(perm_shadow[8'(b10 + lo[2])], fr[0] - one, fr[1], fr[2]),
                grad_dot(perm_shadow[8'(b10 + hi[2])], fr[0] - one, fr[1],
                         fr[2] - one), w);
      n11 = mix(grad_dot(perm_shadow[8'(b11 + lo[2])], fr[0] - one, fr[1] - one,
                         fr[2]),
                grad_dot(perm_shadow[8'(b11 + hi[2])], fr[0] - one, fr[1] - one,
                         fr[2] - one), w);
      n0 = mix(n00, n01, v);
      n1 = mix(n10, n11, v);
      r = mix(n0, n1, u);
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r[17:0];
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one item; update the shadow table or queue the expected noise.
   // Valid stays high after acceptance until the next gap or drain drops it.
   task automatic send_item(logic mode, logic [31:0] px, logic [31:0] py,
                            logic [31:0] pz, logic [7:0] idx, logic [7:0] val,
                            bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_pos_x       <= px;
      req_pos_y       <= py;
      req_pos_z       <= pz;
      req_entry_index <= idx;
      req_entry_value <= val;
      do @(posedge clock); while (!req_ready);
      if (mode == MODE_WRITE) perm_shadow[idx] = val;
      else noise_expected.push_back(noise_at(px, py, pz));
      @(negedge clock);
   endtask

   task automatic write_wrap(logic [CfgIdxWidth-1:0] idx, logic [8:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      wrap_shadow[idx] = val;
      @(negedge clock);
   endtask

   // Drop valid, wait for all results, then let any trailing table write settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (noise_expected.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic set_wraps(logic [8:0] wx, logic [8:0] wy, logic [8:0] wz);
      drain();
      write_wrap(CFG_WRAP_X, wx);
      write_wrap(CFG_WRAP_Y, wy);
      write_wrap(CFG_WRAP_Z, wz);
      csr_valid <= 1'b0;
   endtask

   // Fill every table entry so no lookup touches an unwritten byte.
   task automatic test_table_fill();
      for (int i = 0; i < 256; i++)
         send_item(MODE_WRITE, $urandom, $urandom, $urandom, 8'(i), 8'($urandom),
                   $urandom_range(0, 3) != 0);
   endtask

   // Directed points: field extremes, cell edges, all-ones index/value.
   task automatic test_directed();
      send_item(MODE_EVAL, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00);
      send_item(MODE_EVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'hFF);
      send_item(MODE_EVAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h00, 8'h00);
      send_item(MODE_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hAA, 8'h55);
      send_item(MODE_EVAL, 32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0000, 8'h00, 8'h00);
      send_item(MODE_EVAL, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 8'h00, 8'h00);
      send_item(MODE_EVAL, 32'h00FF_7FFF, 32'hFF00_0001, 32'h0100_C000, 8'h00, 8'h00);
      send_item(MODE_EVAL, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_CCCC, 8'h00, 8'h00);
      // Rewrite entries 0 and 255 with extreme values, then evaluate through them.
      send_item(MODE_WRITE, 32'h0, 32'h0, 32'h0, 8'h00, 8'hFF);
      send_item(MODE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                8'h00);
      send_item(MODE_EVAL, 32'h0000_4000, 32'h0000_C000, 32'h0000_2000, 8'h00, 8'h00);
      send_item(MODE_EVAL, 32'h00FF_4000, 32'h00FF_C000, 32'h00FF_2000, 8'h00, 8'h00);
   endtask

   // Random stream: mostly evaluations, some table rewrites.
   task automatic test_random(int count);
      logic [31:0] px, py, pz;
      for (int n = 0; n < count; n++) begin
         px = $urandom; py = $urandom; pz = $urandom;
         if ($urandom_range(0, 2) == 0) begin
            // Keep near the origin so small wraps and cell edges show up.
            px = 32'($signed(px) >>> $urandom_range(8, 15));
            py = 32'($signed(py) >>> $urandom_range(8, 15));
            pz = 32'($signed(pz) >>> $urandom_range(8, 15));
         end
         if ($urandom_range(0, 9) == 0)
            send_item(MODE_WRITE, px, py, pz, 8'($urandom), 8'($urandom));
         else
            send_item(MODE_EVAL, px, py, pz, 8'($urandom), 8'($urandom));
      end
   endtask

   // Result checker: compare each accepted noise value with the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (noise_expected.size() == 0) begin
            $display("%0t: unexpected noise_value %0d", $time, rsp_noise_value);
            fail_count++;
         end else begin
            logic [17:0] exp_val;
            exp_val = noise_expected.pop_front();
            if (rsp_noise_value !== exp_val) begin
               $display("%0t: noise_value expected %0d actual %0d", $time,
                        $signed(exp_val), rsp_noise_value);
               fail_count++;
            end
         end
      end
   end

   // Receiver stalls: random-length stalls between ready cycles,
   // with stall-free stretches.
   always @(negedge clock) begin
      if (!rsp_stall_on) begin
         rsp_ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold  <= gap_len();
      end
   end

   // Watchdog: count cycles with no handshake on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      wrap_shadow[0] = '0; wrap_shadow[1] = '0; wrap_shadow[2] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_table_fill();
      test_directed();
      set_wraps(9'd256, 9'd256, 9'd256);
      test_directed();
      set_wraps(9'd1, 9'd2, 9'd4);
      test_directed();
      test_random(120);
      rsp_stall_on = 1'b0;
      set_wraps(9'd16, 9'd8, 9'd32);
      test_random(120);
      rsp_stall_on = 1'b1;
      // Non-power-of-two periods and the over-range register value.
      set_wraps(9'd5, 9'd100, 9'd511);
      test_random(120);
      set_wraps(9'd128, 9'd64, 9'd3);
      test_random(120);
      set_wraps(9'd0, 9'd0, 9'd0);
      test_random(120);
      drain();
      if (fail_count == 0 && noise_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
